// File: hw/rtl/uqp_pkg.sv
// ----------------------------------------------------------------------------
// uqp_pkg: shared types and constants of the storage port init handshake
// Operation codes, register selects, phase codes, SA step words and the
// result beat layout.
// ----------------------------------------------------------------------------
package uqp_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned BASE_W  = 31;
	localparam int unsigned SLOTS_W = 8;
	localparam int unsigned LOG_W   = 3;
	localparam int unsigned VEC_W   = 7;
	localparam int unsigned IVEC_W  = 9;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_INIT  = 2'd2,
		OP_RSVD  = 2'd3
	} uqp_op_t;

	localparam logic REG_IP = 1'b0;
	localparam logic REG_SA = 1'b1;

	localparam logic [PHASE_W-1:0] PH_UNINIT = 3'd0;
	localparam logic [PHASE_W-1:0] PH_STEP1  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_STEP2  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_STEP3  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_STEP4  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

	localparam logic [DATA_W-1:0] SA_STEP1 = 16'h0800;
	localparam logic [DATA_W-1:0] SA_STEP2 = 16'h1000;
	localparam logic [DATA_W-1:0] SA_STEP3 = 16'h2000;
	localparam logic [DATA_W-1:0] SA_STEP4 = 16'h4042;
	localparam logic [DATA_W-1:0] SA_DONE  = 16'h0000;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               interrupt_request;
		logic               poll_request;
		logic               ring_clear_request;
		logic [PHASE_W-1:0] init_phase;
		logic [BASE_W-1:0]  ring_base_address;
		logic [SLOTS_W-1:0] response_ring_slots;
		logic [SLOTS_W-1:0] command_ring_slots;
		logic [IVEC_W-1:0]  interrupt_vector;
		logic               purge_interrupt_enable;
	} uqp_result_t;

endpackage

// File: hw/rtl/uqp_if.sv
// ----------------------------------------------------------------------------
// uqp_req_if / uqp_rsp_if: valid/ready channels of the port
// Request carries one bus access or init event, response one result beat.
// ----------------------------------------------------------------------------
interface uqp_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 operation;
	logic                       reg_select;
	logic [uqp_pkg::DATA_W-1:0] write_data;

	modport source (output valid, operation, reg_select, write_data, input ready);
	modport sink   (input valid, operation, reg_select, write_data, output ready);
endinterface

interface uqp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [uqp_pkg::DATA_W-1:0]  read_data;
	logic                        interrupt_request;
	logic                        poll_request;
	logic                        ring_clear_request;
	logic [uqp_pkg::PHASE_W-1:0] init_phase;
	logic [uqp_pkg::BASE_W-1:0]  ring_base_address;
	logic [uqp_pkg::SLOTS_W-1:0] response_ring_slots;
	logic [uqp_pkg::SLOTS_W-1:0] command_ring_slots;
	logic [uqp_pkg::IVEC_W-1:0]  interrupt_vector;
	logic                        purge_interrupt_enable;

	modport source (output valid, read_data, interrupt_request, poll_request,
		ring_clear_request, init_phase, ring_base_address, response_ring_slots,
		command_ring_slots, interrupt_vector, purge_interrupt_enable, input ready);
	modport sink   (input valid, read_data, interrupt_request, poll_request,
		ring_clear_request, init_phase, ring_base_address, response_ring_slots,
		command_ring_slots, interrupt_vector, purge_interrupt_enable, output ready);
endinterface

// File: hw/rtl/uqp_core.sv
// ----------------------------------------------------------------------------
// uqp_core: IP/SA register decode and init step sequencer
// Holds the handshake state, updates it on each accepted beat and forms
// the result beat from the state after the access.
// ----------------------------------------------------------------------------
module uqp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	uqp_req_if.sink              req,
	input  logic                 buf_ready,
	output logic                 res_valid,
	output uqp_pkg::uqp_result_t res
);
	import uqp_pkg::*;

	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [DATA_W-1:0]  status_q, status_n;
	logic [7:0]         step1_lo_q, step1_lo_n;
	logic [VEC_W-1:0]   vec_q, vec_n;
	logic               irq_en_q, irq_en_n;
	logic [LOG_W-1:0]   resp_log_q, resp_log_n;
	logic [LOG_W-1:0]   cmd_log_q, cmd_log_n;
	logic [BASE_W-1:0]  base_q, base_n;
	logic               purge_q, purge_n;

	logic              fire;
	uqp_op_t           op;
	logic [DATA_W-1:0] wd;
	logic [DATA_W-1:0] rd;
	logic              irq, poll, clr;

	assign req.ready = buf_ready;
	assign fire      = req.valid && buf_ready;
	assign op        = uqp_op_t'(req.operation);
	assign wd        = req.write_data;

	always_comb begin
		phase_n    = phase_q;
		status_n   = status_q;
		step1_lo_n = step1_lo_q;
		vec_n      = vec_q;
		irq_en_n   = irq_en_q;
		resp_log_n = resp_log_q;
		cmd_log_n  = cmd_log_q;
		base_n     = base_q;
		purge_n    = purge_q;
		rd         = '0;
		irq        = 1'b0;
		poll       = 1'b0;
		clr        = 1'b0;
		unique case (op)
			OP_INIT: begin
				phase_n  = PH_STEP1;
				status_n = SA_STEP1;
			end
			OP_READ: begin
				if (req.reg_select == REG_SA) begin
					rd = status_q;
				end else if (phase_q == PH_DONE) begin
					poll = 1'b1;
				end
			end
			OP_WRITE: begin
				if (req.reg_select == REG_IP) begin
					phase_n  = PH_STEP1;
					status_n = SA_STEP1;
				end else begin
					unique case (phase_q)
						PH_UNINIT, PH_STEP1: begin
							step1_lo_n = wd[7:0];
							vec_n      = wd[6:0];
							irq_en_n   = wd[7];
							resp_log_n = wd[10:8];
							cmd_log_n  = wd[13:11];
							phase_n    = PH_STEP2;
							status_n   = SA_STEP2 | {8'd0, wd[15:8]};
							irq        = wd[7] && (wd[6:0] != '0);
						end
						PH_STEP2: begin
							base_n   = {15'd0, wd[15:1], 1'b0};
							purge_n  = wd[0];
							phase_n  = PH_STEP3;
							status_n = SA_STEP3 | {8'd0, step1_lo_q};
							irq      = irq_en_q && (vec_q != '0);
						end
						PH_STEP3: begin
							base_n   = {base_q[30:16] | wd[14:0], base_q[15:0]};
							phase_n  = PH_STEP4;
							status_n = SA_STEP4;
							clr      = 1'b1;
							irq      = irq_en_q && (vec_q != '0);
						end
						PH_STEP4: begin
							// GO bit
							if (wd[0]) begin
								phase_n  = PH_DONE;
								status_n = SA_DONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			OP_RSVD: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_STEP1;
			status_q   <= SA_STEP1;
			step1_lo_q <= '0;
			vec_q      <= '0;
			irq_en_q   <= 1'b0;
			resp_log_q <= '0;
			cmd_log_q  <= '0;
			base_q     <= '0;
			purge_q    <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_n;
			status_q   <= status_n;
			step1_lo_q <= step1_lo_n;
			vec_q      <= vec_n;
			irq_en_q   <= irq_en_n;
			resp_log_q <= resp_log_n;
			cmd_log_q  <= cmd_log_n;
			base_q     <= base_n;
			purge_q    <= purge_n;
		end
	end

	assign res_valid = fire;

	always_comb begin
		res.read_data              = rd;
		res.interrupt_request      = irq;
		res.poll_request           = poll;
		res.ring_clear_request     = clr;
		res.init_phase             = phase_n;
		res.ring_base_address      = base_n;
		res.response_ring_slots    = SLOTS_W'(1) << resp_log_n;
		res.command_ring_slots     = SLOTS_W'(1) << cmd_log_n;
		res.interrupt_vector       = {vec_n, 2'b00};
		res.purge_interrupt_enable = purge_n;
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_UNINIT && phase_q <= PH_DONE)
		else $error("phase left the step range");

	a_done_sa_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) == (status_q == SA_DONE))
		else $error("SA word out of step with phase");

	a_clear_step4: assert property (@(posedge clk) disable iff (!arst_n)
		fire && clr |=> phase_q == PH_STEP4 && status_q == SA_STEP4)
		else $error("ring clear without entering step 4");

	a_irq_vec: assert property (@(posedge clk) disable iff (!arst_n)
		fire && irq |=> vec_q != '0 && irq_en_q)
		else $error("interrupt with zero vector or disabled");

endmodule

// File: hw/rtl/uqp_outbuf.sv
// ----------------------------------------------------------------------------
// uqp_outbuf: result register with skid stage
// Keeps the request side moving while a result beat waits on the sink.
// ----------------------------------------------------------------------------
module uqp_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  uqp_pkg::uqp_result_t in_data,
	output logic                 in_ready,
	uqp_rsp_if.source            rsp
);
	import uqp_pkg::*;

	uqp_result_t out_q, skid_q;
	logic        valid_q, skid_valid_q;
	logic        out_free;

	assign in_ready = !skid_valid_q;
	assign out_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				valid_q      <= skid_valid_q || in_valid;
				skid_valid_q <= 1'b0;
			end else if (in_valid && !skid_valid_q) begin
				// output stalled: park the new beat
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end
		if (!out_free && in_valid && !skid_valid_q) begin
			skid_q <= in_data;
		end
	end

	assign rsp.valid                  = valid_q;
	assign rsp.read_data              = out_q.read_data;
	assign rsp.interrupt_request      = out_q.interrupt_request;
	assign rsp.poll_request           = out_q.poll_request;
	assign rsp.ring_clear_request     = out_q.ring_clear_request;
	assign rsp.init_phase             = out_q.init_phase;
	assign rsp.ring_base_address      = out_q.ring_base_address;
	assign rsp.response_ring_slots    = out_q.response_ring_slots;
	assign rsp.command_ring_slots     = out_q.command_ring_slots;
	assign rsp.interrupt_vector       = out_q.interrupt_vector;
	assign rsp.purge_interrupt_enable = out_q.purge_interrupt_enable;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> valid_q)
		else $error("skid holds a beat while output is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && rsp.ready |=> !skid_valid_q && valid_q)
		else $error("skid beat not moved to output");

endmodule

// File: hw/rtl/storage_port_init_handshake.sv
// ----------------------------------------------------------------------------
// storage_port_init_handshake: IP/SA host port with four-step init
// One bus access or bus init per request beat, one result beat each.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   req     | in  | operation, reg_select, write_data
//   rsp     | out | read_data, irq/poll/ring-clear flags, phase, ring setup
//
// One beat per cycle sustained while rsp keeps up; state updates at the accept
// edge, with the result held in the output register (or skid stage) for rsp.
// Reset: phase is step 1, SA reads 0x0800, captured setup is zero.
// A stalled rsp is absorbed by a one-beat skid stage; req.ready drops only
// when both the output register and the skid stage hold beats.
// ----------------------------------------------------------------------------
module storage_port_init_handshake (
	input  logic      clk,
	input  logic      arst_n,
	uqp_req_if.sink   req,
	uqp_rsp_if.source rsp
);
	import uqp_pkg::*;

	logic        buf_ready;
	logic        res_valid;
	uqp_result_t res;

	uqp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.buf_ready (buf_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	uqp_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_data  (res),
		.in_ready (buf_ready),
		.rsp      (rsp)
	);

endmodule

// File: dv/storage_port_init_handshake_tb.sv
// ----------------------------------------------------------------------------
// storage_port_init_handshake_tb: self-checking bench for the IP/SA port
// Drives bus accesses and init events on req and checks every rsp beat
// against an in-bench model of the four-step init handshake. It runs a
// directed walk through the steps, then random sessions under three
// sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module storage_port_init_handshake_tb;
	import uqp_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned MAX_REPORTS  = 10;

	logic clk;
	logic arst_n;

	uqp_req_if req_if ();
	uqp_rsp_if rsp_if ();

	storage_port_init_handshake u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// port model state
	logic [PHASE_W-1:0] hs_phase;
	logic [DATA_W-1:0]  sa_word;
	logic [DATA_W-1:0]  step1_word;
	logic [VEC_W-1:0]   vec_field;
	logic               int_en;
	logic [LOG_W-1:0]   rsp_log;
	logic [LOG_W-1:0]   cmd_log;
	logic [BASE_W-1:0]  ring_base;
	logic               purge_en;

	uqp_result_t expected_beats[$];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned items_sent;
	int unsigned fail_count;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic reset_port_model();
		hs_phase   = PH_STEP1;
		sa_word    = SA_STEP1;
		step1_word = '0;
		vec_field  = '0;
		int_en     = 1'b0;
		rsp_log    = '0;
		cmd_log    = '0;
		ring_base  = '0;
		purge_en   = 1'b0;
	endtask

	function automatic uqp_result_t predict_access(uqp_op_t op, logic sel,
		logic [DATA_W-1:0] wd);
		uqp_result_t r;
		r = '0;
		case (op)
			OP_INIT: begin
				hs_phase = PH_STEP1;
				sa_word  = SA_STEP1;
			end
			OP_READ: begin
				if (sel == REG_SA)
					r.read_data = sa_word;
				else if (hs_phase == PH_DONE)
					r.poll_request = 1'b1;
			end
			OP_WRITE: begin
				if (sel == REG_IP) begin
					hs_phase = PH_STEP1;
					sa_word  = SA_STEP1;
				end else begin
					case (hs_phase)
						PH_UNINIT, PH_STEP1: begin
							step1_word = wd;
							vec_field  = wd[6:0];
							int_en     = wd[7];
							rsp_log    = wd[10:8];
							cmd_log    = wd[13:11];
							hs_phase   = PH_STEP2;
							sa_word    = SA_STEP2 | {8'h00, wd[15:8]};
							r.interrupt_request = int_en && (vec_field != '0);
						end
						PH_STEP2: begin
							ring_base = {15'd0, wd[15:1], 1'b0};
							purge_en  = wd[0];
							hs_phase  = PH_STEP3;
							sa_word   = SA_STEP3 | {8'h00, step1_word[7:0]};
							r.interrupt_request = int_en && (vec_field != '0);
						end
						PH_STEP3: begin
							ring_base = ring_base | {wd[14:0], 16'h0000};
							hs_phase  = PH_STEP4;
							sa_word   = SA_STEP4;
							r.ring_clear_request = 1'b1;
							r.interrupt_request  = int_en && (vec_field != '0);
						end
						PH_STEP4: begin
							// only a GO bit moves the port on
							if (wd[0]) begin
								hs_phase = PH_DONE;
								sa_word  = SA_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		r.init_phase             = hs_phase;
		r.ring_base_address      = ring_base;
		r.response_ring_slots    = 8'd1 << rsp_log;
		r.command_ring_slots     = 8'd1 << cmd_log;
		r.interrupt_vector       = {vec_field, 2'b00};
		r.purge_interrupt_enable = purge_en;
		return r;
	endfunction

	function automatic string beat_text(uqp_result_t b);
		return $sformatf({"rd=%h irq=%b poll=%b clr=%b ph=%0d base=%h",
			" rsl=%0d csl=%0d vec=%0d pie=%b"},
			b.read_data, b.interrupt_request, b.poll_request, b.ring_clear_request,
			b.init_phase, b.ring_base_address, b.response_ring_slots,
			b.command_ring_slots, b.interrupt_vector, b.purge_interrupt_enable);
	endfunction

	always @(posedge clk) begin : check_beat
		uqp_result_t got;
		uqp_result_t want;
		string       bad;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
			got.read_data              = rsp_if.read_data;
			got.interrupt_request      = rsp_if.interrupt_request;
			got.poll_request           = rsp_if.poll_request;
			got.ring_clear_request     = rsp_if.ring_clear_request;
			got.init_phase             = rsp_if.init_phase;
			got.ring_base_address      = rsp_if.ring_base_address;
			got.response_ring_slots    = rsp_if.response_ring_slots;
			got.command_ring_slots     = rsp_if.command_ring_slots;
			got.interrupt_vector       = rsp_if.interrupt_vector;
			got.purge_interrupt_enable = rsp_if.purge_interrupt_enable;
			if (expected_beats.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected rsp beat: %s", beat_text(got));
			end else begin
				want = expected_beats.pop_front();
				bad  = "";
				if (got.read_data !== want.read_data) bad = {bad, " read_data"};
				if (got.interrupt_request !== want.interrupt_request) bad = {bad, " irq"};
				if (got.poll_request !== want.poll_request) bad = {bad, " poll"};
				if (got.ring_clear_request !== want.ring_clear_request) bad = {bad, " clr"};
				if (got.init_phase !== want.init_phase) bad = {bad, " phase"};
				if (got.ring_base_address !== want.ring_base_address) bad = {bad, " base"};
				if (got.response_ring_slots !== want.response_ring_slots) bad = {bad, " rsl"};
				if (got.command_ring_slots !== want.command_ring_slots) bad = {bad, " csl"};
				if (got.interrupt_vector !== want.interrupt_vector) bad = {bad, " vec"};
				if (got.purge_interrupt_enable !== want.purge_interrupt_enable)
					bad = {bad, " pie"};
				if (bad != "") begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("rsp mismatch on%s", bad);
						$display("  expected %s", beat_text(want));
						$display("  actual   %s", beat_text(got));
					end
				end
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_access(uqp_op_t op, logic sel, logic [DATA_W-1:0] wd);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.operation  <= op;
		req_if.reg_select <= sel;
		req_if.write_data <= wd;
		do @(posedge clk); while (!req_if.ready);
		expected_beats.insert(expected_beats.size(), predict_access(op, sel, wd));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_reads(int unsigned n);
		repeat (n) send_access(OP_READ, 1'($urandom), 16'($urandom));
	endtask

	// mostly a restart, then three setup writes, GO, with reads mixed in; sometimes cut short
	task automatic run_session();
		int unsigned step;
		if ($urandom_range(0, 99) < 85) begin
			if ($urandom_range(0, 1))
				send_access(OP_INIT, 1'($urandom), 16'($urandom));
			else
				send_access(OP_WRITE, REG_IP, 16'($urandom));
		end
		for (step = 1; step <= 3; step++) begin
			send_reads($urandom_range(0, 2));
			if ($urandom_range(0, 99) < 6)
				return;
			send_access(OP_WRITE, REG_SA, 16'($urandom));
		end
		send_reads($urandom_range(0, 1));
		repeat ($urandom_range(0, 2)) send_access(OP_WRITE, REG_SA, 16'($urandom) & 16'hfffe);
		send_access(OP_WRITE, REG_SA, 16'($urandom) | 16'h0001);
		send_reads($urandom_range(1, 3));
		if ($urandom_range(0, 3) == 0)
			send_access(OP_WRITE, REG_SA, 16'($urandom));
	endtask

	task automatic run_random(int unsigned n);
		int unsigned stop_at;
		int unsigned pause_at;
		bit          paused;
		stop_at  = items_sent + n;
		pause_at = items_sent + n / 2;
		paused   = 1'b0;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 15)
				send_access(uqp_op_t'($urandom_range(0, 3)), 1'($urandom), 16'($urandom));
			else
				run_session();
			if (!paused && items_sent >= pause_at) begin
				drain_results();
				paused = 1'b1;
			end
		end
		drain_results();
	endtask

	task automatic test_directed_handshake();
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_access(OP_READ, REG_SA, 16'hffff);
		send_access(OP_READ, REG_IP, 16'h0000);
		send_access(OP_RSVD, REG_SA, 16'hffff);
		send_access(OP_WRITE, REG_SA, 16'hffff);
		send_access(OP_READ, REG_SA, 16'h0000);
		send_access(OP_WRITE, REG_SA, 16'hffff);
		send_access(OP_READ, REG_SA, 16'h0000);
		send_access(OP_WRITE, REG_SA, 16'hffff);
		send_access(OP_READ, REG_SA, 16'h0000);
		send_access(OP_WRITE, REG_SA, 16'hfffe);
		send_access(OP_WRITE, REG_SA, 16'h0001);
		send_access(OP_READ, REG_SA, 16'h0000);
		send_access(OP_READ, REG_IP, 16'h0000);
		send_access(OP_WRITE, REG_SA, 16'hffff);
		send_access(OP_WRITE, REG_IP, 16'ha5a5);
		send_access(OP_READ, REG_SA, 16'h0000);
		// interrupt enable with a zero vector must stay quiet
		send_access(OP_WRITE, REG_SA, 16'h0080);
		send_access(OP_WRITE, REG_SA, 16'h0000);
		send_access(OP_INIT, REG_SA, 16'hffff);
		send_access(OP_WRITE, REG_SA, 16'h0000);
		send_access(OP_WRITE, REG_SA, 16'h0000);
		send_access(OP_WRITE, REG_SA, 16'h0000);
		send_access(OP_WRITE, REG_SA, 16'h0001);
		send_access(OP_INIT, REG_IP, 16'h0000);
		drain_results();
	endtask

	task automatic test_sender_heavy_idle();
		tx_idle_pct = 38;
		rx_idle_pct = 76;
		run_random(410);
	endtask

	task automatic test_receiver_heavy_idle();
		tx_idle_pct = 76;
		rx_idle_pct = 38;
		run_random(410);
	endtask

	task automatic test_no_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(410);
	endtask

	initial begin
		tx_idle_pct       = 0;
		rx_idle_pct       = 0;
		items_sent        = 0;
		fail_count        = 0;
		cycle_count       = 0;
		req_if.valid      = 1'b0;
		req_if.operation  = OP_READ;
		req_if.reg_select = REG_IP;
		req_if.write_data = '0;
		reset_port_model();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_handshake();
		test_sender_heavy_idle();
		test_receiver_heavy_idle();
		test_no_idle();

		rx_idle_pct = 0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_beats.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: storage_port_init_handshake.f
hw/rtl/uqp_pkg.sv
hw/rtl/uqp_if.sv
hw/rtl/uqp_core.sv
hw/rtl/uqp_outbuf.sv
hw/rtl/storage_port_init_handshake.sv
dv/storage_port_init_handshake_tb.sv
